/* rtl/core/rdpp_pkg.sv */
// Package: shared constants of the random dissolve position picker.
package rdpp_pkg;

  localparam int COLUMNS_DEF = 40;
  localparam int ROWS_DEF    = 25;

  localparam int RAND_W  = 15;
  localparam int COL_W   = 6;
  localparam int ROW_W   = 5;
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 4;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_FILL_CHAR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_COLOR = 2'd1;

  localparam logic [CHAR_W-1:0]  FILL_CHAR_RST  = 8'd32;
  localparam logic [COLOR_W-1:0] FILL_COLOR_RST = 4'd0;

endpackage

/* rtl/core/random_dissolve_position_picker.sv */
// Top level: draws every screen cell once per pass, in random order.
//
//   channel  direction  handshake             payload
//   in_      request in in_valid / in_stall   in_random_value[14:0]
//   out_     result out out_valid / out_stall out_column, out_row, out_draw_char,
//                                             out_draw_color, out_last
//   cfg_     write in   cfg_we                cfg_index, cfg_data
//
// From acceptance a request passes RD1, RD2, DIV and PUT to a loaded result; the next
// is taken in the cycle after the result is loaded, so none is taken while one is in
// progress. The single read port of the free-cell table sets this: the last free entry
// and the drawn entry are read in turn, then DIV and PUT split the position into row
// and column. After reset and after the final cell of each pass, a sweep through all
// COLUMNS*ROWS entries rewrites the table in identity order while no request is taken.
// A stalled result holds in the output register; a new request is still taken then.
module random_dissolve_position_picker
  import rdpp_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [RAND_W-1:0]     in_random_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COL_W-1:0]      out_column,
  output logic [ROW_W-1:0]      out_row,
  output logic [CHAR_W-1:0]     out_draw_char,
  output logic [COLOR_W-1:0]    out_draw_color,
  output logic                  out_last,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int RW    = $clog2(CELLS + 1);
  localparam int CW    = $clog2(COLUMNS + 1);
  // Exact reciprocal for position / COLUMNS over all AW-bit positions.
  localparam int DS    = AW + $clog2(COLUMNS);
  localparam int DM    = ((1 << DS) + COLUMNS - 1) / COLUMNS;
  localparam int MW    = DS + 1;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD1  = 3'd2;
  localparam logic [2:0] S_RD2  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_PUT  = 3'd5;

  logic [2:0]          state_r, state_nxt;
  logic [RW-1:0]       rem_r, rem_nxt;
  logic [AW-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic                last_r, last_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]   fill_char_r;
  logic [COLOR_W-1:0]  fill_color_r;

  logic [AW-1:0]       idx_r;
  logic [AW-1:0]       last_val_r;
  logic [AW-1:0]       pos_r;
  logic [AW-1:0]       q_r;
  logic [COL_W-1:0]    out_column_r;
  logic [ROW_W-1:0]    out_row_r;
  logic [CHAR_W-1:0]   out_draw_char_r;
  logic [COLOR_W-1:0]  out_draw_color_r;
  logic                out_last_r;

  logic                accept;
  logic                put_go;
  logic [RW+RAND_W-1:0] scale_prod;
  logic [AW+MW-1:0]    div_prod;
  logic [AW+CW-1:0]    qc_prod;
  logic [AW-1:0]       col_full;
  logic [RW-1:0]       rem_dec;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_wdata, ram_raddr, ram_rdata;

  assign accept     = (state_r == S_IDLE) && in_valid;
  assign put_go     = !out_valid_r || !out_stall;
  assign in_stall   = (state_r != S_IDLE);
  assign rem_dec    = rem_r - RW'(1);
  assign scale_prod = (RW+RAND_W)'(rem_r) * (RW+RAND_W)'(in_random_value);
  assign div_prod   = (AW+MW)'(pos_r) * (AW+MW)'(DM);
  assign qc_prod    = (AW+CW)'(q_r) * (AW+CW)'(COLUMNS);
  assign col_full   = AW'((AW+CW)'(pos_r) - qc_prod);

  // Read the last free entry at acceptance, the drawn entry in the cycle after.
  assign ram_raddr = (state_r == S_IDLE) ? AW'(rem_dec) : idx_r;
  assign ram_we    = (state_r == S_CLR) || (state_r == S_RD2);
  assign ram_waddr = (state_r == S_CLR) ? clr_cnt_r : idx_r;
  assign ram_wdata = (state_r == S_CLR) ? clr_cnt_r : last_val_r;

  rdpp_ram #(
    .WIDTH(AW),
    .DEPTH(CELLS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    rem_nxt       = rem_r;
    clr_cnt_nxt   = clr_cnt_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_CLR: begin
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(CELLS - 1)) begin
          clr_cnt_nxt = '0;
          state_nxt   = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_RD1;
        end
      end
      S_RD1: begin
        state_nxt = S_RD2;
      end
      S_RD2: begin
        // Take the cell; restart the count once the pass is used up.
        last_nxt = (rem_dec == '0);
        rem_nxt  = (rem_dec == '0) ? RW'(CELLS) : rem_dec;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        state_nxt = S_PUT;
      end
      S_PUT: begin
        if (put_go) begin
          out_valid_nxt = 1'b1;
          state_nxt     = last_r ? S_CLR : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      rem_r        <= RW'(CELLS);
      clr_cnt_r    <= '0;
      last_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      fill_char_r  <= FILL_CHAR_RST;
      fill_color_r <= FILL_COLOR_RST;
    end else begin
      state_r     <= state_nxt;
      rem_r       <= rem_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_FILL_CHAR:  fill_char_r  <= cfg_data;
          REG_FILL_COLOR: fill_color_r <= cfg_data[COLOR_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r <= AW'(scale_prod >> RAND_W);
    end
    if (state_r == S_RD1) begin
      last_val_r <= ram_rdata;
    end
    if (state_r == S_RD2) begin
      pos_r <= ram_rdata;
    end
    if (state_r == S_DIV) begin
      q_r <= AW'(div_prod >> DS);
    end
    if (state_r == S_PUT && put_go) begin
      out_column_r     <= COL_W'(col_full);
      out_row_r        <= ROW_W'(q_r);
      out_draw_char_r  <= fill_char_r;
      out_draw_color_r <= fill_color_r;
      out_last_r       <= last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_column     = out_column_r;
  assign out_row        = out_row_r;
  assign out_draw_char  = out_draw_char_r;
  assign out_draw_color = out_draw_color_r;
  assign out_last       = out_last_r;

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (rem_r != '0) && (rem_r <= RW'(CELLS)))
    else $error("free count out of range");

  a_idx_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD1) |-> (RW'(idx_r) < rem_r))
    else $error("drawn index beyond free entries");

  a_pass_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUT && put_go && last_r) |=> (state_r == S_CLR && clr_cnt_r == '0))
    else $error("final draw not followed by table sweep");

  a_last_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && last_r) |-> (rem_r == RW'(CELLS)))
    else $error("final draw without count restart");

endmodule

/* rtl/core/rdpp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rdpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
